// ----- design/ldd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldd_pkg
// Shared request codes and controller states for the deadlock detector.
// ----------------------------------------------------------------------------
package ldd_pkg;

  // Request kinds.
  localparam logic [1:0] REQ_WAIT    = 2'd0;
  localparam logic [1:0] REQ_GRANT   = 2'd1;
  localparam logic [1:0] REQ_RELEASE = 2'd2;
  localparam logic [1:0] REQ_DETECT  = 2'd3;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_BUILD,
    ST_PRUNE,
    ST_DONE
  } state_t;

endpackage

// ----- design/lock_deadlock_detector.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lock_deadlock_detector
// Resource allocation graph with wait and hold matrices and cycle detection.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; exactly one result
// follows, shown for one cycle with done high. Wait, grant and release requests
// pass through ST_UPD to ST_DONE: the wait and hold memories are read at the
// accepting edge and written back in the next cycle. A detect request first
// reads every process row of the wait memory and every lock row of the hold
// memory, one address per cycle, to build the wait-for matrix, then prunes
// processes with no live successor, one pass per cycle, up to PROCS passes,
// and then raises done. busy stays high through the done cycle, so the next
// request is taken at the earliest in the cycle after done. Both memories are
// cleared by reset through per-row valid bits. The receiver cannot stall the
// result.
module lock_deadlock_detector #(
  parameter int PROCS = 16,
  parameter int LOCKS = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] req_type,
  input  logic [3:0] pid,
  input  logic [2:0] lock_id,
  output logic       done,
  output logic       deadlock
);

  localparam int PW  = (PROCS > 1) ? $clog2(PROCS) : 1;
  localparam int LW  = (LOCKS > 1) ? $clog2(LOCKS) : 1;
  localparam int MX  = (PROCS > LOCKS) ? PROCS : LOCKS;
  localparam int CW  = $clog2(MX + 2);

  // Memories and their per-row valid bits.
  logic [LOCKS-1:0] wmem [PROCS];
  logic [PROCS-1:0] hmem [LOCKS];
  logic [PROCS-1:0] wvalid;
  logic [LOCKS-1:0] hvalid;
  logic [LOCKS-1:0] wrd;
  logic [PROCS-1:0] hrd;
  logic             wrd_ok, hrd_ok;

  ldd_pkg::state_t state, state_next;
  logic [1:0]       kind;
  logic [PW-1:0]    cp;
  logic [LW-1:0]    cl;
  logic             inrange;
  logic [CW-1:0]    cnt;
  logic [PROCS-1:0] wf [PROCS];
  logic [LOCKS-1:0] wrow [PROCS];
  logic [PROCS-1:0] hrow [LOCKS];
  logic [PROCS-1:0] live, live_next;
  logic             result;

  logic [PW-1:0] raddr_p;
  logic [LW-1:0] raddr_l;
  logic          rd_en;

  assign busy = (state != ldd_pkg::ST_IDLE);

  // Read addresses: the request's entry for updates, the sweep counter for build.
  always_comb begin
    rd_en   = 1'b0;
    raddr_p = cp;
    raddr_l = cl;
    if (state == ldd_pkg::ST_IDLE) begin
      rd_en   = start;
      raddr_p = PW'(pid);
      raddr_l = LW'(lock_id);
    end else if (state == ldd_pkg::ST_BUILD) begin
      rd_en   = 1'b1;
      raddr_p = cnt[PW-1:0];
      raddr_l = cnt[LW-1:0];
    end
  end

  // Synchronous memory reads with valid masking.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      wrd    <= wmem[raddr_p];
      hrd    <= hmem[raddr_l];
      wrd_ok <= wvalid[raddr_p];
      hrd_ok <= hvalid[raddr_l];
    end
  end

  logic [LOCKS-1:0] wcur;
  logic [PROCS-1:0] hcur;
  assign wcur = wrd_ok ? wrd : '0;
  assign hcur = hrd_ok ? hrd : '0;

  // Write back of an update.
  always_ff @(posedge clk) begin
    if (state == ldd_pkg::ST_UPD && inrange) begin
      case (kind)
        ldd_pkg::REQ_WAIT: begin
          wmem[cp] <= wcur | (LOCKS'(1) << cl);
        end
        ldd_pkg::REQ_GRANT: begin
          wmem[cp] <= wcur & ~(LOCKS'(1) << cl);
          hmem[cl] <= hcur | (PROCS'(1) << cp);
        end
        ldd_pkg::REQ_RELEASE: begin
          hmem[cl] <= hcur & ~(PROCS'(1) << cp);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wvalid <= '0;
      hvalid <= '0;
    end else if (state == ldd_pkg::ST_UPD && inrange) begin
      case (kind)
        ldd_pkg::REQ_WAIT:    wvalid[cp] <= 1'b1;
        ldd_pkg::REQ_GRANT: begin
          wvalid[cp] <= 1'b1;
          hvalid[cl] <= 1'b1;
        end
        ldd_pkg::REQ_RELEASE: hvalid[cl] <= 1'b1;
        default: begin
        end
      endcase
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ldd_pkg::ST_IDLE: begin
        if (start) begin
          state_next = (req_type == ldd_pkg::REQ_DETECT) ? ldd_pkg::ST_BUILD
                                                         : ldd_pkg::ST_UPD;
        end
      end
      ldd_pkg::ST_UPD:   state_next = ldd_pkg::ST_DONE;
      ldd_pkg::ST_BUILD: begin
        if (cnt == CW'(MX)) state_next = ldd_pkg::ST_PRUNE;
      end
      ldd_pkg::ST_PRUNE: begin
        if (live_next == live || cnt == CW'(PROCS - 1)) state_next = ldd_pkg::ST_DONE;
      end
      ldd_pkg::ST_DONE:  state_next = ldd_pkg::ST_IDLE;
      default:           state_next = ldd_pkg::ST_IDLE;
    endcase
  end

  // One prune pass: drop live processes with no live successor.
  always_comb begin
    live_next = live;
    for (int p = 0; p < PROCS; p++) begin
      if ((wf[p] & live) == '0) live_next[p] = 1'b0;
    end
  end

  // Outputs.
  always_comb begin
    done     = (state == ldd_pkg::ST_DONE);
    deadlock = done && result;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ldd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ldd_pkg::ST_IDLE: begin
        kind    <= req_type;
        cp      <= PW'(pid);
        cl      <= LW'(lock_id);
        inrange <= (32'(pid) < PROCS) && (32'(lock_id) < LOCKS);
        cnt     <= '0;
        result  <= 1'b0;
        live    <= '1;
      end
      ldd_pkg::ST_BUILD: begin
        // Data read last cycle belongs to address cnt-1.
        if (cnt != '0) begin
          if (32'(cnt) - 1 < PROCS) wrow[cnt[PW-1:0] - PW'(1)] <= wcur;
          if (32'(cnt) - 1 < LOCKS) hrow[LW'(cnt - CW'(1))] <= hcur;
        end
        if (cnt == CW'(MX)) begin
          cnt <= '0;
        end else begin
          cnt <= cnt + CW'(1);
        end
      end
      ldd_pkg::ST_PRUNE: begin
        live   <= live_next;
        cnt    <= cnt + CW'(1);
        result <= (live_next != '0);
      end
      default: begin
      end
    endcase
  end

  // Wait-for rows: a process points at every holder of a lock it waits on.
  logic [PROCS-1:0] wf_row [PROCS];
  always_comb begin
    for (int p = 0; p < PROCS; p++) begin
      wf_row[p] = '0;
      for (int l = 0; l < LOCKS; l++) begin
        if (wrow[p][l]) wf_row[p] = wf_row[p] | hrow[l];
      end
    end
  end

  always_comb begin
    for (int p = 0; p < PROCS; p++) begin
      wf[p] = wf_row[p];
    end
  end

  // Assertions.
  a_done_one: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held two cycles");
  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("done while idle");
  a_dl_detect: assert property (@(posedge clk) disable iff (rst)
    deadlock |-> done) else $error("deadlock without done");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("request not taken");

endmodule

// ----- tb/lock_deadlock_detector_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lock_deadlock_detector_tb
// Drives wait, grant, release and detect requests into the deadlock detector,
// predicts each deadlock flag from a private copy of the graph, and compares
// every result with the oldest prediction.
// ----------------------------------------------------------------------------
module lock_deadlock_detector_tb;

  localparam int NPROC = 16;
  localparam int NLOCK = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 60;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic [1:0] req_type = ldd_pkg::REQ_WAIT;
  logic [3:0] pid = '0;
  logic [2:0] lock_id = '0;
  logic       busy;
  logic       done;
  logic       deadlock;

  // Private copy of the graph.
  logic [NLOCK-1:0] waits_on [NPROC];
  logic [NPROC-1:0] held_by [NLOCK];

  bit   flag_queue [$];
  int   errors = 0;
  int   idle_cycles = 0;
  int   send_idle_pct = 0;

  lock_deadlock_detector dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req_type(req_type),
    .pid(pid), .lock_id(lock_id), .done(done), .deadlock(deadlock)
  );

  always #5 clk = ~clk;

  // Builds the wait-for graph and prunes processes until nothing changes.
  function automatic bit graph_has_cycle();
    logic [NPROC-1:0] succ [NPROC];
    logic [NPROC-1:0] live;
    logic [NPROC-1:0] next;
    live = '1;
    for (int p = 0; p < NPROC; p++) begin
      succ[p] = '0;
      for (int l = 0; l < NLOCK; l++) begin
        if (waits_on[p][l]) succ[p] |= held_by[l];
      end
    end
    for (int pass = 0; pass < NPROC; pass++) begin
      next = live;
      for (int p = 0; p < NPROC; p++) begin
        if (live[p] && (succ[p] & live) == '0) next[p] = 1'b0;
      end
      if (next == live) break;
      live = next;
    end
    return live != '0;
  endfunction

  // Applies one request to the graph and returns the expected flag.
  function automatic bit apply_request(logic [1:0] kind, logic [3:0] p, logic [2:0] l);
    case (kind)
      ldd_pkg::REQ_DETECT: return graph_has_cycle();
      ldd_pkg::REQ_WAIT: waits_on[p][l] = 1'b1;
      ldd_pkg::REQ_GRANT: begin
        held_by[l][p] = 1'b1;
        waits_on[p][l] = 1'b0;
      end
      default: held_by[l][p] = 1'b0;
    endcase
    return 1'b0;
  endfunction

  task automatic report(string what);
    errors++;
    $display("mismatch: %s at %0t", what, $time);
  endtask

  // Result checker.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (flag_queue.size() == 0) begin
        report("result with no request outstanding");
      end else begin
        if (deadlock !== flag_queue[0]) begin
          report($sformatf("deadlock got %b expected %b", deadlock, flag_queue[0]));
        end
        void'(flag_queue.pop_front());
      end
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL lock_deadlock_detector");
        $finish;
      end
    end
  end

  // Sends one request and waits for it to be taken; start stays high after
  // acceptance and is either reused by the next request or dropped.
  task automatic send_request(logic [1:0] kind, logic [3:0] p, logic [2:0] l);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    req_type <= kind;
    pid <= p;
    lock_id <= l;
    @(posedge clk);
    while (busy) @(posedge clk);
    flag_queue.push_back(apply_request(kind, p, l));
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (flag_queue.size() != 0) @(posedge clk);
  endtask

  // Extremes of the fields, every kind, and the corner cases of the graph.
  task automatic test_directed();
    send_request(ldd_pkg::REQ_DETECT, 4'd0, 3'd0);
    send_request(ldd_pkg::REQ_RELEASE, 4'd15, 3'd7);
    send_request(ldd_pkg::REQ_GRANT, 4'd3, 3'd2);
    send_request(ldd_pkg::REQ_GRANT, 4'd15, 3'd2);
    send_request(ldd_pkg::REQ_WAIT, 4'd3, 3'd5);
    send_request(ldd_pkg::REQ_WAIT, 4'd3, 3'd5);
    send_request(ldd_pkg::REQ_GRANT, 4'd9, 3'd5);
    send_request(ldd_pkg::REQ_WAIT, 4'd9, 3'd2);
    send_request(ldd_pkg::REQ_DETECT, 4'd15, 3'd7);
    send_request(ldd_pkg::REQ_RELEASE, 4'd3, 3'd2);
    send_request(ldd_pkg::REQ_DETECT, 4'd0, 3'd0);
    send_request(ldd_pkg::REQ_RELEASE, 4'd15, 3'd2);
    send_request(ldd_pkg::REQ_DETECT, 4'd0, 3'd0);
    send_request(ldd_pkg::REQ_WAIT, 4'd0, 3'd7);
    send_request(ldd_pkg::REQ_GRANT, 4'd0, 3'd7);
    send_request(ldd_pkg::REQ_WAIT, 4'd0, 3'd7);
    send_request(ldd_pkg::REQ_DETECT, 4'd0, 3'd0);
    send_request(ldd_pkg::REQ_RELEASE, 4'd0, 3'd7);
    send_request(ldd_pkg::REQ_RELEASE, 4'd0, 3'd7);
    send_request(ldd_pkg::REQ_DETECT, 4'd5, 3'd1);
    // Pause until every result has arrived before going on.
    wait_drained();
  endtask

  // Random traffic, three in four requests on processes and locks 0 to 3, so that cycles form often.
  task automatic test_random(int count, int idle_pct);
    logic [1:0] kind;
    int r;
    send_idle_pct = idle_pct;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 35) kind = ldd_pkg::REQ_WAIT;
      else if (r < 60) kind = ldd_pkg::REQ_GRANT;
      else if (r < 80) kind = ldd_pkg::REQ_RELEASE;
      else kind = ldd_pkg::REQ_DETECT;
      if ($urandom_range(3) == 0) begin
        send_request(kind, 4'($urandom), 3'($urandom));
      end else begin
        send_request(kind, 4'($urandom_range(3)), 3'($urandom_range(3)));
      end
    end
  endtask

  initial begin
    for (int p = 0; p < NPROC; p++) waits_on[p] = '0;
    for (int l = 0; l < NLOCK; l++) held_by[l] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(500, 0);
    test_random(300, 86);
    test_random(300, 22);
    test_random(350, 0);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS lock_deadlock_detector");
    end else begin
      $display("FAIL lock_deadlock_detector");
    end
    $finish;
  end

endmodule
